>>> sv/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types, codes and constants of the screen fade alpha unit.
// ----------------------------------------------------------------------------
package sfa_pkg;

    // Field and datapath widths.
    localparam int TIME_W    = 32;
    localparam int NOW_W     = 31;
    localparam int TICK_W    = 16;
    localparam int COLOR_W   = 8;
    localparam int Q_FRAC    = 16;
    localparam int QUO_W     = COLOR_W + Q_FRAC;
    localparam int SPEED_W   = 26;
    localparam int DIFF_W    = TIME_W + 1;
    localparam int PROD_W    = 2 * SPEED_W;
    localparam int VAL_W     = PROD_W - Q_FRAC;

    // Request codes.
    localparam logic [1:0] REQ_QUERY = 2'd0;
    localparam logic [1:0] REQ_FADE  = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;

    // Dark fade-in of a level start: five seconds of hold, five of ramp.
    localparam int TICKS_PER_SEC = 4096;
    localparam int DARK_SECONDS  = 5;
    localparam int DARK_ALPHA_PS = 51;
    localparam logic [TICK_W-1:0]  DARK_TICKS = TICK_W'(TICKS_PER_SEC * DARK_SECONDS);
    localparam logic [COLOR_W-1:0] DARK_PEAK  = 8'd255;
    localparam logic [SPEED_W-1:0] DARK_SPEED =
        SPEED_W'((DARK_ALPHA_PS * (1 << Q_FRAC)) / TICKS_PER_SEC);

    // One input word.
    typedef struct packed {
        logic [1:0]         req_type;
        logic [NOW_W-1:0]   now_ticks;
        logic [TICK_W-1:0]  duration_ticks;
        logic [TICK_W-1:0]  hold_ticks;
        logic               fade_out;
        logic [COLOR_W-1:0] red_in;
        logic [COLOR_W-1:0] green_in;
        logic [COLOR_W-1:0] blue_in;
        logic [COLOR_W-1:0] peak_alpha;
        logic               dark_start;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [COLOR_W-1:0] fade_alpha;
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
    } t_out_word;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Fade state and load strobe toward the alpha evaluator.
    typedef struct packed {
        logic                      load;
        logic [NOW_W-1:0]          now;
        logic [TIME_W-1:0]         ramp_end;
        logic [TIME_W-1:0]         hold_end;
        logic signed [SPEED_W-1:0] speed;
        logic [COLOR_W-1:0]        peak;
        logic                      out_dir;
    } t_alpha_ctl;

endpackage

>>> sv/sfa_stream_if.sv
// ----------------------------------------------------------------------------
// sfa_stream_if
// Valid/ready channel that carries one word of a given payload type.
// ----------------------------------------------------------------------------
interface sfa_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/screen_fade_alpha_unit.sv
// ----------------------------------------------------------------------------
// screen_fade_alpha_unit
// Screen fade opacity generator: updates fade state per request word and
// returns the fade alpha at the word's time together with the fade color.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload      Handshake
//  i_req     in   t_in_word    valid/ready, taken on valid && ready
//  o_rsp     out  t_out_word   valid/ready, one word per request
//
// A query or level init moves from accept through SUM0, SUM1, WDIV, MUL, FIN.
// A fade command with nonzero duration waits in WDIV for the 24-step serial
// divider that forms the ramp speed. One shared adder forms the end times.
// Reset is synchronous and clears all fade state to zero. The result sits in
// an output register, so a new request is taken while it waits; the block
// stalls only when a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
module screen_fade_alpha_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfa_stream_if.sink    i_req,
    sfa_stream_if.source  o_rsp
);
    import sfa_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM0 = 3'd1;
    localparam logic [2:0] S_SUM1 = 3'd2;
    localparam logic [2:0] S_WDIV = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    t_in_word                  req;
    logic                      accept;
    logic                      out_load;
    logic                      div_start;
    logic [QUO_W-1:0]          quotient;
    t_div_stat                 div_stat;
    t_alpha_ctl                alpha_ctl;
    logic [COLOR_W-1:0]        alpha;
    logic [TIME_W-1:0]         sum_a;
    logic [TICK_W-1:0]         sum_b;
    logic [TIME_W-1:0]         sum;

    logic [2:0]                r_state, n_state;
    logic [TIME_W-1:0]         r_ramp_end;
    logic [TIME_W-1:0]         r_hold_end;
    logic signed [SPEED_W-1:0] r_speed;
    logic [COLOR_W-1:0]        r_peak;
    logic                      r_out_dir;
    logic [COLOR_W-1:0]        r_red, r_green, r_blue;
    logic [NOW_W-1:0]          r_now;
    logic [TICK_W-1:0]         r_sum_x, r_sum_y;
    logic                      r_first_ramp;
    logic                      r_need_sum;
    logic                      r_need_div;
    logic [TIME_W-1:0]         r_first;
    logic                      r_out_valid;
    t_out_word                 r_out;

    assign req       = i_req.data;
    assign i_req.ready = (r_state == S_IDLE);
    assign accept    = i_req.valid && (r_state == S_IDLE);
    assign out_load  = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);
    assign div_start = accept && (req.req_type == REQ_FADE) && (req.duration_ticks != '0);

    // Shared adder for the two end times: now plus the first offset, then
    // that sum plus the second offset.
    assign sum_a = (r_state == S_SUM0) ? {1'b0, r_now} : r_first;
    assign sum_b = (r_state == S_SUM0) ? r_sum_x : r_sum_y;
    assign sum   = sum_a + {{(TIME_W-TICK_W){1'b0}}, sum_b};

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SUM0;
                end
            end
            S_SUM0: n_state = S_SUM1;
            S_SUM1: n_state = S_WDIV;
            S_WDIV: begin
                if (!div_stat.busy) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_FIN;
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request scratch registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now <= req.now_ticks;
            if (req.req_type == REQ_FADE) begin
                r_sum_x      <= req.fade_out ? req.duration_ticks : req.hold_ticks;
                r_sum_y      <= req.fade_out ? req.hold_ticks : req.duration_ticks;
                r_first_ramp <= req.fade_out;
            end else begin
                r_sum_x      <= DARK_TICKS;
                r_sum_y      <= DARK_TICKS;
                r_first_ramp <= 1'b0;
            end
        end
        if (r_state == S_SUM0) begin
            r_first <= sum;
        end
    end

    // Fade state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_end <= '0;
            r_hold_end <= '0;
            r_speed    <= '0;
            r_peak     <= '0;
            r_out_dir  <= 1'b0;
            r_red      <= '0;
            r_green    <= '0;
            r_blue     <= '0;
            r_need_sum <= 1'b0;
            r_need_div <= 1'b0;
        end else begin
            if (accept) begin
                r_need_sum <= 1'b0;
                r_need_div <= 1'b0;
                if (req.req_type == REQ_FADE) begin
                    r_red     <= req.red_in;
                    r_green   <= req.green_in;
                    r_blue    <= req.blue_in;
                    r_peak    <= req.peak_alpha;
                    r_out_dir <= req.fade_out;
                    r_speed   <= '0;
                    r_ramp_end <= {{(TIME_W-TICK_W){1'b0}}, req.duration_ticks};
                    r_hold_end <= {{(TIME_W-TICK_W){1'b0}}, req.hold_ticks};
                    if (req.duration_ticks != '0) begin
                        r_need_sum <= 1'b1;
                        r_need_div <= 1'b1;
                    end
                end else if (req.req_type == REQ_INIT) begin
                    r_red     <= '0;
                    r_green   <= '0;
                    r_blue    <= '0;
                    r_out_dir <= 1'b0;
                    if (req.dark_start) begin
                        r_peak     <= DARK_PEAK;
                        r_speed    <= DARK_SPEED;
                        r_need_sum <= 1'b1;
                    end else begin
                        r_peak     <= '0;
                        r_speed    <= '0;
                        r_ramp_end <= '0;
                        r_hold_end <= '0;
                    end
                end
            end
            // End times from the shared adder.
            if (r_need_sum && (r_state == S_SUM0)) begin
                if (r_first_ramp) begin
                    r_ramp_end <= sum;
                end else begin
                    r_hold_end <= sum;
                end
            end
            if (r_need_sum && (r_state == S_SUM1)) begin
                if (r_first_ramp) begin
                    r_hold_end <= sum;
                end else begin
                    r_ramp_end <= sum;
                end
            end
            // Signed ramp speed once the divider has finished.
            if (r_need_div && div_stat.done) begin
                if (r_out_dir) begin
                    r_speed <= -$signed({{(SPEED_W-QUO_W){1'b0}}, quotient});
                end else begin
                    r_speed <= $signed({{(SPEED_W-QUO_W){1'b0}}, quotient});
                end
            end
        end
    end

    sfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_peak     (req.peak_alpha),
        .i_divisor  (req.duration_ticks),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    assign alpha_ctl.load     = (r_state == S_MUL);
    assign alpha_ctl.now      = r_now;
    assign alpha_ctl.ramp_end = r_ramp_end;
    assign alpha_ctl.hold_end = r_hold_end;
    assign alpha_ctl.speed    = r_speed;
    assign alpha_ctl.peak     = r_peak;
    assign alpha_ctl.out_dir  = r_out_dir;

    sfa_alpha u_alpha (
        .i_clk   (i_clk),
        .i_ctl   (alpha_ctl),
        .o_alpha (alpha)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out.fade_alpha <= alpha;
            r_out.red_out    <= r_red;
            r_out.green_out  <= r_green;
            r_out.blue_out   <= r_blue;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // The divider only runs while a request is in flight.
    a_div_busy_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state != S_IDLE))
        else $error("divider busy while sequencer idle");

    // A request always leaves the idle state on the next cycle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SUM0))
        else $error("accepted request did not start the sequence");

    // A negative ramp speed only ever comes with a fade-out.
    a_speed_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (!r_speed[SPEED_W-1] || r_out_dir))
        else $error("negative ramp speed on a fade-in");

    // A delivered alpha never exceeds the stored peak.
    a_alpha_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out.fade_alpha <= $past(r_peak)))
        else $error("fade alpha above peak");

endmodule

>>> sv/sfa_div.sv
// ----------------------------------------------------------------------------
// sfa_div
// Restoring divider, one quotient bit per cycle: (peak << 16) / duration.
// ----------------------------------------------------------------------------
module sfa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sfa_pkg::COLOR_W-1:0] i_peak,
    input  logic [sfa_pkg::TICK_W-1:0]  i_divisor,
    output logic [sfa_pkg::QUO_W-1:0]   o_quotient,
    output sfa_pkg::t_div_stat          o_stat
);
    import sfa_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [TICK_W-1:0]  r_rem,  n_rem;
    logic [QUO_W-1:0]   r_quo,  n_quo;
    logic [TICK_W-1:0]  r_dsr,  n_dsr;
    logic [CNT_W-1:0]   r_cnt,  n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [TICK_W:0]    shifted;
    logic [TICK_W+1:0]  trial;

    // Trial subtraction of the divisor from the shifted remainder.
    assign shifted = {r_rem, r_quo[QUO_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_dsr};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = {i_peak, {Q_FRAC{1'b0}}};
            n_dsr  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // The dividend shifts out on top while quotient bits enter below.
            if (trial[TICK_W+1]) begin
                n_rem = shifted[TICK_W-1:0];
                n_quo = {r_quo[QUO_W-2:0], 1'b0};
            end else begin
                n_rem = trial[TICK_W-1:0];
                n_quo = {r_quo[QUO_W-2:0], 1'b1};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QUO_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> sv/sfa_alpha.sv
// ----------------------------------------------------------------------------
// sfa_alpha
// Alpha evaluator: registered ramp product, then rounding, offset and clamp.
// ----------------------------------------------------------------------------
module sfa_alpha (
    input  logic                        i_clk,
    input  sfa_pkg::t_alpha_ctl         i_ctl,
    output logic [sfa_pkg::COLOR_W-1:0] o_alpha
);
    import sfa_pkg::*;

    localparam logic signed [SPEED_W-1:0] DIFF_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic signed [SPEED_W-1:0] DIFF_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

    logic signed [DIFF_W-1:0]  diff;
    logic signed [SPEED_W-1:0] diff_sat;
    logic                      expired;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_expired;
    logic signed [PROD_W-1:0]  prod_adj;
    logic signed [VAL_W-1:0]   val;
    logic signed [VAL_W:0]     val_off;
    logic signed [VAL_W:0]     peak_ext;

    // Time left on the ramp; saturating it keeps every clamp decision intact
    // since the speed magnitude is at least one when it is not zero.
    assign diff    = $signed({1'b0, i_ctl.ramp_end}) - $signed({2'b00, i_ctl.now});
    assign expired = (i_ctl.hold_end < {1'b0, i_ctl.now})
                  && (i_ctl.ramp_end < {1'b0, i_ctl.now});

    always_comb begin
        if (diff > DIFF_W'(DIFF_MAX)) begin
            diff_sat = DIFF_MAX;
        end else if (diff < DIFF_W'(DIFF_MIN)) begin
            diff_sat = DIFF_MIN;
        end else begin
            diff_sat = diff[SPEED_W-1:0];
        end
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod    <= diff_sat * i_ctl.speed;
            r_expired <= expired;
        end
    end

    // Divide by 65536 truncating toward zero, add peak on fade-out, clamp.
    assign prod_adj = r_prod + (r_prod[PROD_W-1] ? PROD_W'((1 << Q_FRAC) - 1) : '0);
    assign val      = prod_adj[PROD_W-1:Q_FRAC];
    assign peak_ext = $signed({{(VAL_W+1-COLOR_W){1'b0}}, i_ctl.peak});
    assign val_off  = i_ctl.out_dir ? ({val[VAL_W-1], val} + peak_ext)
                                    : {val[VAL_W-1], val};

    always_comb begin
        if (r_expired) begin
            o_alpha = '0;
        end else if (val_off > peak_ext) begin
            o_alpha = i_ctl.peak;
        end else if (val_off[VAL_W]) begin
            o_alpha = '0;
        end else begin
            o_alpha = val_off[COLOR_W-1:0];
        end
    end

endmodule

>>> test/tb_screen_fade_alpha_unit.sv
// ----------------------------------------------------------------------------
// tb_screen_fade_alpha_unit
// Self-checking testbench of the screen fade alpha unit. Request words are
// fed through the request channel while a local fade predictor tracks the
// fade state and works out the alpha and color of every accepted word. Each
// response word is compared with the oldest prediction, under random idling
// on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb_screen_fade_alpha_unit;
    import sfa_pkg::*;

    // Unused request code, which the block treats as a query.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Dark fade-in of a level start: 5 s hold, 5 s ramp, 51 alpha per second.
    localparam logic [31:0] FADE_IN_TICKS = 32'd20480;
    localparam logic [7:0]  FADE_IN_PEAK  = 8'd255;
    localparam logic signed [25:0] FADE_IN_SPEED = 26'sd816;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int STALL_CYCLES   = 400;
    localparam int SETTLE_CYCLES  = 40;

    logic clk;
    logic rst_n;

    sfa_stream_if #(.t_payload(t_in_word))  req_if ();
    sfa_stream_if #(.t_payload(t_out_word)) rsp_if ();

    screen_fade_alpha_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Predicted fade state.
    logic [31:0]        fade_ramp_end;
    logic [31:0]        fade_hold_end;
    logic signed [25:0] fade_speed;
    logic [7:0]         fade_peak;
    logic               fade_out_dir;
    logic [7:0]         fade_red;
    logic [7:0]         fade_green;
    logic [7:0]         fade_blue;

    t_out_word alpha_expect_q[$];

    int src_idle_pct;
    int snk_idle_pct;
    int hold_off_req;
    int hold_off_seen;
    int stall_left;
    int fail_count;
    int words_sent;
    int fades_sent;
    int inits_sent;
    int results_checked;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Update the predicted fade state with one request word and return the
    // response that the block must give for it.
    function automatic t_out_word apply_fade_request(input t_in_word w);
        logic [23:0] mag;
        longint      diff;
        longint      level;
        t_out_word   r;
        case (w.req_type)
            REQ_FADE: begin
                fade_red      = w.red_in;
                fade_green    = w.green_in;
                fade_blue     = w.blue_in;
                fade_peak     = w.peak_alpha;
                fade_out_dir  = w.fade_out;
                fade_speed    = '0;
                fade_ramp_end = 32'(w.duration_ticks);
                fade_hold_end = 32'(w.hold_ticks);
                if (w.duration_ticks != '0) begin
                    mag = {w.peak_alpha, 16'h0000} / {8'h00, w.duration_ticks};
                    if (w.fade_out) begin
                        fade_speed    = -$signed({2'b00, mag});
                        fade_ramp_end = 32'(w.now_ticks) + 32'(w.duration_ticks);
                        fade_hold_end = fade_ramp_end + 32'(w.hold_ticks);
                    end else begin
                        fade_speed    = $signed({2'b00, mag});
                        fade_hold_end = 32'(w.now_ticks) + 32'(w.hold_ticks);
                        fade_ramp_end = fade_hold_end + 32'(w.duration_ticks);
                    end
                end
            end
            REQ_INIT: begin
                fade_out_dir = 1'b0;
                fade_red     = '0;
                fade_green   = '0;
                fade_blue    = '0;
                if (w.dark_start) begin
                    fade_peak     = FADE_IN_PEAK;
                    fade_speed    = FADE_IN_SPEED;
                    fade_hold_end = 32'(w.now_ticks) + FADE_IN_TICKS;
                    fade_ramp_end = fade_hold_end + FADE_IN_TICKS;
                end else begin
                    fade_peak     = '0;
                    fade_speed    = '0;
                    fade_hold_end = '0;
                    fade_ramp_end = '0;
                end
            end
            default: ;
        endcase

        // Opacity at the word's time: zero once both times have passed.
        if (fade_hold_end < {1'b0, w.now_ticks} && fade_ramp_end < {1'b0, w.now_ticks}) begin
            level = 0;
        end else begin
            diff  = $signed({32'd0, fade_ramp_end}) - $signed({33'd0, w.now_ticks});
            level = (diff * longint'(fade_speed)) / 65536;
            if (fade_out_dir) begin
                level = level + longint'(fade_peak);
            end
            if (level > longint'(fade_peak)) begin
                level = longint'(fade_peak);
            end else if (level < 0) begin
                level = 0;
            end
        end
        r.fade_alpha = 8'(level);
        r.red_out    = fade_red;
        r.green_out  = fade_green;
        r.blue_out   = fade_blue;
        return r;
    endfunction

    function automatic t_in_word make_request(
        input logic [1:0]  kind,
        input logic [30:0] now,
        input logic [15:0] dur,
        input logic [15:0] hold,
        input logic        out_dir,
        input logic [7:0]  red,
        input logic [7:0]  green,
        input logic [7:0]  blue,
        input logic [7:0]  peak,
        input logic        dark
    );
        t_in_word w;
        w.req_type       = kind;
        w.now_ticks      = now;
        w.duration_ticks = dur;
        w.hold_ticks     = hold;
        w.fade_out       = out_dir;
        w.red_in         = red;
        w.green_in       = green;
        w.blue_in        = blue;
        w.peak_alpha     = peak;
        w.dark_start     = dark;
        return w;
    endfunction

    // A word with every field random.
    function automatic t_in_word random_request();
        return make_request(2'($urandom_range(0, 3)), 31'($urandom), 16'($urandom),
                            16'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom), 1'($urandom));
    endfunction

    // Offer one request word, with a random gap first, until it is taken.
    task automatic send_request(input t_in_word w);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        do @(posedge clk); while (!req_if.ready);
        alpha_expect_q.push_back(apply_fade_request(w));
        words_sent++;
        if (w.req_type == REQ_FADE) fades_sent++;
        if (w.req_type == REQ_INIT) inits_sent++;
    endtask

    // Stop offering and wait until every predicted response has come back.
    task automatic drain_responses();
        req_if.valid <= 1'b0;
        while (alpha_expect_q.size() != 0) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Response side: check each taken word, then choose the next ready.
    always @(posedge clk) begin
        t_out_word exp_w;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (alpha_expect_q.size() == 0) begin
                $display("%0t: response with none expected, actual %h", $time, rsp_if.data);
                fail_count++;
            end else begin
                exp_w = alpha_expect_q.pop_front();
                check_field("fade_alpha", exp_w.fade_alpha, rsp_if.data.fade_alpha);
                check_field("red_out",    exp_w.red_out,    rsp_if.data.red_out);
                check_field("green_out",  exp_w.green_out,  rsp_if.data.green_out);
                check_field("blue_out",   exp_w.blue_out,   rsp_if.data.blue_out);
                results_checked++;
            end
        end
        if (hold_off_req != hold_off_seen) begin
            hold_off_seen = hold_off_req;
            stall_left    = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Watchdog: ends the run after a long stretch with no word moving.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[screen_fade_alpha_unit] ERROR");
        $finish;
    end

    // Extremes of the fields, both fade directions, zero duration, the dark
    // fade-in across its hold, ramp and end, the clearing init and the spare
    // request code.
    task automatic test_directed();
        send_request(make_request(REQ_QUERY, 31'd0, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_request(make_request(REQ_QUERY, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_request(make_request(REQ_SPARE, 31'd12345, 16'd77, 16'd9, 1'b1,
                                  8'h12, 8'h34, 8'h56, 8'h78, 1'b1));
        send_request(make_request(REQ_INIT, 31'd1000, 16'd5, 16'd5, 1'b1,
                                  8'h11, 8'h22, 8'h33, 8'h44, 1'b1));
        send_request(make_request(REQ_QUERY, 31'd1000, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_request(make_request(REQ_QUERY, 31'd21480, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_request(make_request(REQ_QUERY, 31'd31480, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_request(make_request(REQ_QUERY, 31'd41960, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_request(make_request(REQ_QUERY, 31'd41961, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        // Longest fade-out, ending just past the top of the time range.
        send_request(make_request(REQ_FADE, 31'h7FFF_0000, 16'hFFFF, 16'hFFFF, 1'b1,
                                  8'hFF, 8'h00, 8'hA5, 8'hFF, 1'b0));
        send_request(make_request(REQ_QUERY, 31'h7FFF_0000, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_request(make_request(REQ_QUERY, 31'h7FFF_8000, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_request(make_request(REQ_QUERY, 31'h7FFF_FFFF, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        // Shortest fade-in with no hold.
        send_request(make_request(REQ_FADE, 31'd5000, 16'd1, 16'd0, 1'b0,
                                  8'h01, 8'h80, 8'hFE, 8'hC8, 1'b1));
        send_request(make_request(REQ_QUERY, 31'd5000, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_request(make_request(REQ_QUERY, 31'd5001, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_request(make_request(REQ_QUERY, 31'd5002, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        // Zero duration: the times are absolute, not offset by the word's time.
        send_request(make_request(REQ_FADE, 31'd50, 16'd0, 16'd100, 1'b1,
                                  8'h40, 8'h50, 8'h60, 8'h80, 1'b0));
        send_request(make_request(REQ_QUERY, 31'd200, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_request(make_request(REQ_FADE, 31'd10, 16'd0, 16'hFFFF, 1'b0,
                                  8'h7F, 8'hFF, 8'h00, 8'h7F, 1'b0));
        // Zero peak gives zero alpha on a running ramp.
        send_request(make_request(REQ_FADE, 31'd0, 16'd300, 16'd20, 1'b1,
                                  8'h99, 8'h88, 8'h77, 8'h00, 1'b0));
        // Clearing init with every other field set.
        send_request(make_request(REQ_INIT, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        send_request(make_request(REQ_QUERY, 31'd0, 16'd0, 16'd0, 1'b0,
                                  8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        drain_responses();
    endtask

    // Mostly a fade command or level init followed by queries around its
    // ramp and hold, with some fully random words between.
    task automatic test_random_fades(input int count);
        t_in_word    w;
        logic [30:0] base;
        int          span;
        int          n_queries;
        int          sent;
        int          pick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                w = random_request();
                base = ($urandom_range(0, 4) == 0) ? 31'($urandom_range(0, 70000)) : w.now_ticks;
                w.now_ticks = base;
                if (pick < 10) begin
                    w.req_type = REQ_INIT;
                    w.dark_start = ($urandom_range(0, 9) < 7);
                    span = 2 * int'(FADE_IN_TICKS);
                end else begin
                    w.req_type = REQ_FADE;
                    if ($urandom_range(0, 9) < 7) begin
                        w.duration_ticks = 16'($urandom_range(0, 300));
                        w.hold_ticks     = 16'($urandom_range(0, 200));
                    end
                    span = int'(w.duration_ticks) + int'(w.hold_ticks);
                end
                send_request(w);
                sent++;
                n_queries = $urandom_range(2, 8);
                repeat (n_queries) begin
                    w = random_request();
                    w.req_type  = ($urandom_range(0, 9) == 0) ? REQ_SPARE : REQ_QUERY;
                    w.now_ticks = base + 31'($urandom_range(0, span + 64)) - 31'd32;
                    send_request(w);
                    sent++;
                end
            end else begin
                send_request(random_request());
                sent++;
            end
        end
        drain_responses();
    endtask

    // Hold the response side off for a long stretch while words keep coming,
    // so that the block fills up and stops taking requests.
    task automatic test_response_stall();
        t_in_word w;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_off_req <= hold_off_req + 1;
        repeat (30) begin
            w = random_request();
            send_request(w);
        end
        drain_responses();
    endtask

    initial begin
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        rsp_if.ready  = 1'b0;
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        hold_off_req  = 0;
        hold_off_seen = 0;
        stall_left    = 0;
        fail_count    = 0;
        words_sent    = 0;
        fades_sent    = 0;
        inits_sent    = 0;
        results_checked = 0;
        fade_ramp_end = '0;
        fade_hold_end = '0;
        fade_speed    = '0;
        fade_peak     = '0;
        fade_out_dir  = 1'b0;
        fade_red      = '0;
        fade_green    = '0;
        fade_blue     = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 26;
        snk_idle_pct = 86;
        test_directed();
        test_random_fades(300);
        src_idle_pct = 86;
        snk_idle_pct = 26;
        test_random_fades(300);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_fades(300);
        test_response_stall();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (alpha_expect_q.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, alpha_expect_q.size());
            fail_count++;
        end
        $display("Sent %0d requests: %0d fade commands, %0d level inits, the rest queries.",
                 words_sent, fades_sent, inits_sent);
        $display("Checked %0d responses across three idling mixes and a long stall; %0d errors.",
                 results_checked, fail_count);
        if (fail_count == 0) begin
            $display("[screen_fade_alpha_unit] OK");
        end else begin
            $display("[screen_fade_alpha_unit] ERROR");
        end
        $finish;
    end

endmodule
